FILE: rtl/lmsd_pkg.sv
package lmsd_pkg;

    localparam int OPCODE_W   = 2;
    localparam int COORD_W    = 4;
    localparam int COLOUR_W   = 3;
    localparam int SEL_W      = 3;
    localparam int DWELL_W    = 16;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PTR_W = 2;

    localparam logic [DWELL_W-1:0]   DWELL_RESET = 16'd2000;
    localparam logic [SEL_W-1:0]     SEL_IDLE    = 3'd7;
    localparam logic [REG_IDX_W-1:0] REG_DWELL   = 1'b0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK    = 2'd0,
        OP_SET_DOT = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_START   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SELECT   = 3'd1,
        PH_BLANK    = 3'd2,
        PH_SHIFT_HI = 3'd3,
        PH_SHIFT_LO = 3'd4,
        PH_LATCH    = 3'd5,
        PH_UNBLANK  = 3'd6,
        PH_DWELL    = 3'd7
    } phase_t;

    // pin levels decided by the sequencer for one beat; data comes later from the store
    typedef struct packed {
        logic [SEL_W-1:0] row_select_n;
        logic             blank;
        logic             latch;
        logic             shift_clock;
        logic             scanning;
        logic             frame_done;
        logic             load_data;
    } pins_t;

    typedef struct packed {
        logic [SEL_W-1:0] row_select_n;
        logic             blank;
        logic             latch;
        logic             serial_data;
        logic             shift_clock;
        logic             scanning;
        logic             frame_done;
    } result_t;

endpackage

FILE: rtl/lmsd_cmd_if.sv
interface lmsd_cmd_if;
    import lmsd_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [COORD_W-1:0]  dot_column;
    logic [COORD_W-1:0]  dot_row;
    logic [COLOUR_W-1:0] dot_colour;

    modport source (
        output valid,
        output opcode,
        output dot_column,
        output dot_row,
        output dot_colour,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  dot_column,
        input  dot_row,
        input  dot_colour,
        output ready
    );
endinterface

FILE: rtl/lmsd_res_if.sv
interface lmsd_res_if;
    import lmsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEL_W-1:0] row_select_n;
    logic             blank;
    logic             latch;
    logic             serial_data;
    logic             shift_clock;
    logic             scanning;
    logic             frame_done;

    modport source (
        output valid,
        output row_select_n,
        output blank,
        output latch,
        output serial_data,
        output shift_clock,
        output scanning,
        output frame_done,
        input  ready
    );

    modport sink (
        input  valid,
        input  row_select_n,
        input  blank,
        input  latch,
        input  serial_data,
        input  shift_clock,
        input  scanning,
        input  frame_done,
        output ready
    );
endinterface

FILE: rtl/led_matrix_scan_driver.sv
// Channel  Dir  Beat contents
// cmd      in   opcode, dot_column, dot_row, dot_colour
// res      out  row_select_n, blank, latch, serial_data, shift_clock, scanning, frame_done
// apb      in   dwell_ticks at byte address 0
//
// One command beat per cycle while cmd.ready is high; its result beat passes through
// the frame store RAM read stage, then the three-entry result queue.
// Set dot is a read-modify-write of one store line, forwarded to the next beat.
// Reset clears the line valid bits at once, so the store reads as zero with no sweep.
// cmd.ready drops while queued beats plus the one in the store stage fill all three entries.
module led_matrix_scan_driver #(
    parameter int NUM_LINES    = 8,
    parameter int HALF_WIDTH   = 16,
    parameter int BITS_PER_ROW = 96
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lmsd_cmd_if.sink                         cmd,
    lmsd_res_if.source                       res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lmsd_pkg::PADDR_W-1:0]     paddr,
    input  logic [lmsd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lmsd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import lmsd_pkg::*;

    localparam int LINE_W = $clog2(NUM_LINES);
    localparam int BIT_W  = $clog2(BITS_PER_ROW);

    logic                 accept;
    op_t                  op;
    logic [DWELL_W-1:0]   dwell_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [LINE_W-1:0]    seq_line;
    logic [BIT_W-1:0]     seq_bit;
    pins_t                pins;
    logic                 s1_valid;
    result_t              s1_res;
    result_t              q_data;
    logic                 room;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = room;
    assign op        = op_t'(cmd.opcode);

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_DWELL) ? APB_DATA_W'(dwell_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg <= DWELL_RESET;
        end
        else if (psel && penable && pwrite && (reg_idx == REG_DWELL))
        begin
            dwell_reg <= pwdata[DWELL_W-1:0];
        end
    end

    lmsd_seq #(
        .NUM_LINES    (NUM_LINES),
        .BITS_PER_ROW (BITS_PER_ROW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .dwell_ticks (dwell_reg),
        .line_idx    (seq_line),
        .bit_idx     (seq_bit),
        .pins        (pins)
    );

    lmsd_store #(
        .NUM_LINES    (NUM_LINES),
        .HALF_WIDTH   (HALF_WIDTH),
        .BITS_PER_ROW (BITS_PER_ROW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (op),
        .dot_column (cmd.dot_column),
        .dot_row    (cmd.dot_row),
        .dot_colour (cmd.dot_colour),
        .seq_line   (seq_line),
        .seq_bit    (seq_bit),
        .pins       (pins),
        .res_valid  (s1_valid),
        .res        (s1_res)
    );

    lmsd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid),
        .push_data (s1_res),
        .pending   (s1_valid),
        .room      (room),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (q_data)
    );

    assign res.row_select_n = q_data.row_select_n;
    assign res.blank        = q_data.blank;
    assign res.latch        = q_data.latch;
    assign res.serial_data  = q_data.serial_data;
    assign res.shift_clock  = q_data.shift_clock;
    assign res.scanning     = q_data.scanning;
    assign res.frame_done   = q_data.frame_done;
endmodule

FILE: rtl/lmsd_ram.sv
module lmsd_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/lmsd_seq.sv
module lmsd_seq #(
    parameter int NUM_LINES    = 8,
    parameter int BITS_PER_ROW = 96
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  lmsd_pkg::op_t                   op,
    input  logic [lmsd_pkg::DWELL_W-1:0]    dwell_ticks,
    output logic [$clog2(NUM_LINES)-1:0]    line_idx,
    output logic [$clog2(BITS_PER_ROW)-1:0] bit_idx,
    output lmsd_pkg::pins_t                 pins
);
    import lmsd_pkg::*;

    localparam int LINE_W = $clog2(NUM_LINES);
    localparam int BIT_W  = $clog2(BITS_PER_ROW);

    phase_t             phase_reg, phase_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [DWELL_W-1:0] dwell_reg, dwell_next;
    logic [SEL_W-1:0]   row_reg, row_next;
    logic               blank_reg, blank_next;
    logic               latch_reg, latch_next;
    logic               clock_reg, clock_next;
    logic               done;
    logic               load;
    logic               last_bit;
    logic               last_line;

    assign last_bit  = (bit_reg == BIT_W'(BITS_PER_ROW - 1));
    assign last_line = (line_reg == LINE_W'(NUM_LINES - 1));

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    case (phase_reg)
                        PH_SELECT:   phase_next = PH_BLANK;
                        PH_BLANK:    phase_next = PH_SHIFT_HI;
                        PH_SHIFT_HI: phase_next = PH_SHIFT_LO;
                        PH_SHIFT_LO: phase_next = last_bit ? PH_LATCH : PH_SHIFT_HI;
                        PH_LATCH:    phase_next = PH_UNBLANK;
                        PH_UNBLANK:  phase_next = PH_DWELL;
                        PH_DWELL:
                        begin
                            if (dwell_reg == '0)
                            begin
                                phase_next = last_line ? PH_IDLE : PH_BLANK;
                            end
                        end
                        default:     phase_next = phase_reg;
                    endcase
                end
                OP_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next = PH_SELECT;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    always_comb
    begin
        line_next  = line_reg;
        bit_next   = bit_reg;
        dwell_next = dwell_reg;
        row_next   = row_reg;
        blank_next = blank_reg;
        latch_next = latch_reg;
        clock_next = clock_reg;
        done       = 1'b0;
        load       = 1'b0;
        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    case (phase_reg)
                        PH_SELECT:
                        begin
                            row_next = ~SEL_W'(line_reg);
                        end
                        PH_BLANK:
                        begin
                            blank_next = 1'b1;
                            bit_next   = '0;
                        end
                        PH_SHIFT_HI:
                        begin
                            clock_next = 1'b1;
                            load       = 1'b1;
                        end
                        PH_SHIFT_LO:
                        begin
                            clock_next = 1'b0;
                            bit_next   = last_bit ? '0 : bit_reg + 1'b1;
                        end
                        PH_LATCH:
                        begin
                            latch_next = 1'b1;
                        end
                        PH_UNBLANK:
                        begin
                            latch_next = 1'b0;
                            blank_next = 1'b0;
                            dwell_next = dwell_ticks;
                        end
                        PH_DWELL:
                        begin
                            if (dwell_reg != '0)
                            begin
                                dwell_next = dwell_reg - 1'b1;
                            end
                            else if (last_line)
                            begin
                                line_next  = '0;
                                row_next   = SEL_IDLE;
                                blank_next = 1'b1;
                                done       = 1'b1;
                            end
                            else
                            begin
                                line_next = line_reg + 1'b1;
                                row_next  = ~SEL_W'(line_reg + 1'b1);
                            end
                        end
                        default:
                        begin
                            done = 1'b0;
                        end
                    endcase
                end
                OP_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        line_next  = '0;
                        bit_next   = '0;
                        dwell_next = '0;
                    end
                end
                default:
                begin
                    done = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            line_reg  <= '0;
            bit_reg   <= '0;
            dwell_reg <= '0;
            row_reg   <= '0;
            blank_reg <= 1'b1;
            latch_reg <= 1'b0;
            clock_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            line_reg  <= line_next;
            bit_reg   <= bit_next;
            dwell_reg <= dwell_next;
            row_reg   <= row_next;
            blank_reg <= blank_next;
            latch_reg <= latch_next;
            clock_reg <= clock_next;
        end
    end

    assign line_idx = line_reg;
    assign bit_idx  = bit_reg;

    always_comb
    begin
        pins.row_select_n = row_next;
        pins.blank        = blank_next;
        pins.latch        = latch_next;
        pins.shift_clock  = clock_next;
        pins.scanning     = (phase_next != PH_IDLE);
        pins.frame_done   = done;
        pins.load_data    = load;
    end
endmodule

FILE: rtl/lmsd_store.sv
module lmsd_store #(
    parameter int NUM_LINES    = 8,
    parameter int HALF_WIDTH   = 16,
    parameter int BITS_PER_ROW = 96
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  lmsd_pkg::op_t                   op,
    input  logic [lmsd_pkg::COORD_W-1:0]    dot_column,
    input  logic [lmsd_pkg::COORD_W-1:0]    dot_row,
    input  logic [lmsd_pkg::COLOUR_W-1:0]   dot_colour,
    input  logic [$clog2(NUM_LINES)-1:0]    seq_line,
    input  logic [$clog2(BITS_PER_ROW)-1:0] seq_bit,
    input  lmsd_pkg::pins_t                 pins,
    output logic                            res_valid,
    output lmsd_pkg::result_t               res
);
    import lmsd_pkg::*;

    localparam int LINE_W = $clog2(NUM_LINES);
    localparam int BIT_W  = $clog2(BITS_PER_ROW);
    localparam int POS_W  = $clog2(5 * HALF_WIDTH + 16 + BITS_PER_ROW);

    logic [COORD_W-2:0]      dot_line;
    logic                    line_ok;
    logic [LINE_W-1:0]       raddr;
    logic [BITS_PER_ROW-1:0] rdata;

    logic                    s1_valid_reg;
    op_t                     s1_op_reg;
    logic [LINE_W-1:0]       s1_line_reg;
    logic [BIT_W-1:0]        s1_bit_reg;
    logic                    s1_ok_reg;
    logic [COORD_W-1:0]      s1_col_reg;
    logic                    s1_odd_reg;
    logic [COLOUR_W-1:0]     s1_colour_reg;
    pins_t                   s1_pins_reg;

    logic [NUM_LINES-1:0]    line_valid_reg;
    logic                    fwd_valid_reg;
    logic [LINE_W-1:0]       fwd_line_reg;
    logic [BITS_PER_ROW-1:0] fwd_data_reg;
    logic                    pin_data_reg;

    logic [BITS_PER_ROW-1:0] base;
    logic [BITS_PER_ROW-1:0] row_new;
    logic [POS_W-1:0]        pos0, pos1, pos2;
    logic                    we;
    logic                    serial;

    assign dot_line = dot_row[COORD_W-1:1];
    assign line_ok  = (int'(dot_line) < NUM_LINES);
    assign raddr    = (op == OP_SET_DOT) ? LINE_W'(dot_line) : seq_line;

    lmsd_ram #(
        .WIDTH (BITS_PER_ROW),
        .DEPTH (NUM_LINES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (s1_line_reg),
        .wdata (row_new),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= op;
            s1_line_reg   <= raddr;
            s1_bit_reg    <= seq_bit;
            s1_ok_reg     <= line_ok;
            s1_col_reg    <= dot_column;
            s1_odd_reg    <= dot_row[0];
            s1_colour_reg <= dot_colour;
            s1_pins_reg   <= pins;
        end
    end

    // a write issued in the cycle the read was taken is not in rdata yet
    always_comb
    begin
        if (fwd_valid_reg && (fwd_line_reg == s1_line_reg))
        begin
            base = fwd_data_reg;
        end
        else if (line_valid_reg[s1_line_reg])
        begin
            base = rdata;
        end
        else
        begin
            base = '0;
        end
    end

    assign pos0 = POS_W'(s1_col_reg) + (s1_odd_reg ? POS_W'(HALF_WIDTH) : '0);
    assign pos1 = pos0 + POS_W'(2 * HALF_WIDTH);
    assign pos2 = pos0 + POS_W'(4 * HALF_WIDTH);

    always_comb
    begin
        row_new = base;
        for (int i = 0; i < BITS_PER_ROW; i++)
        begin
            if (POS_W'(i) == pos0)
            begin
                row_new[i] = s1_colour_reg[1];
            end
            else if (POS_W'(i) == pos1)
            begin
                row_new[i] = s1_colour_reg[2];
            end
            else if (POS_W'(i) == pos2)
            begin
                row_new[i] = s1_colour_reg[0];
            end
        end
    end

    assign we     = s1_valid_reg && (s1_op_reg == OP_SET_DOT) && s1_ok_reg;
    assign serial = s1_pins_reg.load_data ? base[s1_bit_reg] : pin_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
            fwd_valid_reg  <= 1'b0;
            pin_data_reg   <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= we;
            if (s1_valid_reg && (s1_op_reg == OP_CLEAR))
            begin
                line_valid_reg <= '0;
            end
            else if (we)
            begin
                line_valid_reg[s1_line_reg] <= 1'b1;
            end
            if (s1_valid_reg && s1_pins_reg.load_data)
            begin
                pin_data_reg <= serial;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            fwd_line_reg <= s1_line_reg;
            fwd_data_reg <= row_new;
        end
    end

    assign res_valid = s1_valid_reg;

    always_comb
    begin
        res.row_select_n = s1_pins_reg.row_select_n;
        res.blank        = s1_pins_reg.blank;
        res.latch        = s1_pins_reg.latch;
        res.serial_data  = serial;
        res.shift_clock  = s1_pins_reg.shift_clock;
        res.scanning     = s1_pins_reg.scanning;
        res.frame_done   = s1_pins_reg.frame_done;
    end
endmodule

FILE: rtl/lmsd_outq.sv
module lmsd_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lmsd_pkg::result_t push_data,
    input  logic              pending,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output lmsd_pkg::result_t out_data
);
    import lmsd_pkg::*;

    result_t               entries_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_PTR_W-1:0] count_reg, count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entries_reg[rd_ptr_reg];

    // one beat may still be in the store stage, so leave space for it
    assign room = ((OUTQ_PTR_W + 1)'(count_reg) + (OUTQ_PTR_W + 1)'(pending))
                  < (OUTQ_PTR_W + 1)'(OUTQ_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

FILE: tb/led_matrix_scan_driver_tb.sv
`timescale 1ns / 1ps

module led_matrix_scan_driver_tb;
    import lmsd_pkg::*;

    localparam int LINES    = 8;
    localparam int HALF_W   = 16;
    localparam int ROW_BITS = 96;

    localparam logic [PADDR_W-1:0] DWELL_ADDR = {REG_DWELL, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR = DWELL_ADDR + 3'd4;

    typedef struct packed {
        op_t                 opcode;
        logic [COORD_W-1:0]  dot_column;
        logic [COORD_W-1:0]  dot_row;
        logic [COLOUR_W-1:0] dot_colour;
    } dot_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lmsd_cmd_if cmd_if();
    lmsd_res_if res_if();

    led_matrix_scan_driver u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the scan sequencer and frame store
    logic [ROW_BITS-1:0] panel [LINES];
    phase_t              seq_phase;
    logic [SEL_W-1:0]    cur_line;
    int                  bit_idx;
    logic [DWELL_W-1:0]  dwell_left;
    logic [DWELL_W-1:0]  dwell_setting;
    logic [SEL_W-1:0]    row_pin;
    logic                blank_pin;
    logic                latch_pin;
    logic                data_pin;
    logic                clock_pin;

    dot_cmd_t pending_cmds [$];
    result_t  expected_pins [$];
    dot_cmd_t in_flight;
    result_t  want_pins;

    int mismatches = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int send_gap;
    int recv_stall;
    int hold_left = 0;
    logic hold_req = 1'b0;

    function automatic result_t scan_step(input dot_cmd_t c);
        int      x;
        int      ln;
        logic    done;
        result_t r;
        done = 1'b0;
        case (c.opcode)
            OP_TICK:
            begin
                case (seq_phase)
                    PH_SELECT:
                    begin
                        row_pin   = ~cur_line;
                        seq_phase = PH_BLANK;
                    end
                    PH_BLANK:
                    begin
                        blank_pin = 1'b1;
                        bit_idx   = 0;
                        seq_phase = PH_SHIFT_HI;
                    end
                    PH_SHIFT_HI:
                    begin
                        data_pin  = panel[cur_line][bit_idx];
                        clock_pin = 1'b1;
                        seq_phase = PH_SHIFT_LO;
                    end
                    PH_SHIFT_LO:
                    begin
                        clock_pin = 1'b0;
                        bit_idx++;
                        if (bit_idx >= ROW_BITS)
                        begin
                            bit_idx   = 0;
                            seq_phase = PH_LATCH;
                        end
                        else
                        begin
                            seq_phase = PH_SHIFT_HI;
                        end
                    end
                    PH_LATCH:
                    begin
                        latch_pin = 1'b1;
                        seq_phase = PH_UNBLANK;
                    end
                    PH_UNBLANK:
                    begin
                        latch_pin  = 1'b0;
                        blank_pin  = 1'b0;
                        dwell_left = dwell_setting;
                        seq_phase  = PH_DWELL;
                    end
                    PH_DWELL:
                    begin
                        if (dwell_left != 0)
                        begin
                            dwell_left--;
                        end
                        else if (cur_line == SEL_W'(LINES - 1))
                        begin
                            cur_line  = '0;
                            row_pin   = SEL_IDLE;
                            blank_pin = 1'b1;
                            seq_phase = PH_IDLE;
                            done      = 1'b1;
                        end
                        else
                        begin
                            cur_line++;
                            row_pin   = ~cur_line;
                            seq_phase = PH_BLANK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_SET_DOT:
            begin
                ln = int'(c.dot_row) >> 1;
                x  = int'(c.dot_column) + (c.dot_row[0] ? HALF_W : 0);
                panel[ln][x]              = c.dot_colour[1];
                panel[ln][x + 2 * HALF_W] = c.dot_colour[2];
                panel[ln][x + 4 * HALF_W] = c.dot_colour[0];
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < LINES; i++)
                    panel[i] = '0;
            end
            OP_START:
            begin
                if (seq_phase == PH_IDLE)
                begin
                    cur_line   = '0;
                    bit_idx    = 0;
                    dwell_left = '0;
                    seq_phase  = PH_SELECT;
                end
            end
            default:
            begin
            end
        endcase
        r.row_select_n = row_pin;
        r.blank        = blank_pin;
        r.latch        = latch_pin;
        r.serial_data  = data_pin;
        r.shift_clock  = clock_pin;
        r.scanning     = (seq_phase != PH_IDLE);
        r.frame_done   = done;
        return r;
    endfunction

    function automatic int idle_len();
        return ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(3, 1);
    endfunction

    task automatic check_pin(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
            send_gap     <= 0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
                expected_pins.push_back(scan_step(in_flight));
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap     <= send_gap - 1;
                    cmd_if.valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    in_flight = pending_cmds.pop_front();
                    cmd_if.valid      <= 1'b1;
                    cmd_if.opcode     <= in_flight.opcode;
                    cmd_if.dot_column <= in_flight.dot_column;
                    cmd_if.dot_row    <= in_flight.dot_row;
                    cmd_if.dot_colour <= in_flight.dot_colour;
                    if ($urandom_range(99) < gap_pct)
                        send_gap <= idle_len();
                end
                else
                begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            recv_stall   <= 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_pins.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want_pins = expected_pins.pop_front();
                    check_pin("row_select_n", want_pins.row_select_n, res_if.row_select_n);
                    check_pin("blank", want_pins.blank, res_if.blank);
                    check_pin("latch", want_pins.latch, res_if.latch);
                    check_pin("serial_data", want_pins.serial_data, res_if.serial_data);
                    check_pin("shift_clock", want_pins.shift_clock, res_if.shift_clock);
                    check_pin("scanning", want_pins.scanning, res_if.scanning);
                    check_pin("frame_done", want_pins.frame_done, res_if.frame_done);
                end
            end
            if (recv_stall != 0)
            begin
                recv_stall   <= recv_stall - 1;
                res_if.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                res_if.ready <= 1'b0;
            end
            else if ($urandom_range(99) < stall_pct)
            begin
                recv_stall   <= idle_len() - 1;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_left <= 400;
            hold_req  <= 1'b0;
        end
    end

    task automatic push_cmd(input op_t op, input logic [COORD_W-1:0] col,
                            input logic [COORD_W-1:0] row, input logic [COLOUR_W-1:0] colour);
        dot_cmd_t c;
        c.opcode     = op;
        c.dot_column = col;
        c.dot_row    = row;
        c.dot_colour = colour;
        pending_cmds.push_back(c);
    endtask

    task automatic push_random(input int set_pct, input int clear_pct, input int start_pct);
        int   roll;
        op_t  op;
        roll = $urandom_range(99);
        if (roll < set_pct)
            op = OP_SET_DOT;
        else if (roll < set_pct + clear_pct)
            op = OP_CLEAR;
        else if (roll < set_pct + clear_pct + start_pct)
            op = OP_START;
        else
            op = OP_TICK;
        push_cmd(op, COORD_W'($urandom), COORD_W'($urandom), COLOUR_W'($urandom));
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_random(0, 0, 0);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_if.valid || expected_pins.size() != 0);
    endtask

    task automatic set_pace();
        int pick;
        pick = $urandom_range(2);
        gap_pct   <= (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
        pick = $urandom_range(2);
        stall_pct <= (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == DWELL_ADDR)
            dwell_setting = value[DWELL_W-1:0];
    endtask

    task automatic reg_read_check();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= DWELL_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DATA_W'(dwell_setting))
        begin
            $error("dwell_ticks: expected %0d, got %0d", dwell_setting, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic scan_out_frame();
        int rounds;
        rounds = 0;
        do
        begin
            set_pace();
            repeat (50) push_random(10, 1, 1);
            wait_drained();
            if ($urandom_range(9) == 0)
                reg_write(DWELL_ADDR, APB_DATA_W'($urandom_range(3)));
            rounds++;
        end
        while (seq_phase != PH_IDLE && rounds < 2);
    endtask

    initial
    begin
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = '0;
        cmd_if.dot_column = '0;
        cmd_if.dot_row    = '0;
        cmd_if.dot_colour = '0;
        res_if.ready      = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        for (int i = 0; i < LINES; i++)
            panel[i] = '0;
        seq_phase     = PH_IDLE;
        cur_line      = '0;
        bit_idx       = 0;
        dwell_left    = '0;
        dwell_setting = DWELL_RESET;
        row_pin       = '0;
        blank_pin     = 1'b1;
        latch_pin     = 1'b0;
        data_pin      = 1'b0;
        clock_pin     = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reg_read_check();

        // directed
        gap_pct   <= 20;
        stall_pct <= 20;
        push_cmd(OP_TICK, 4'd15, 4'd15, 3'd7);
        push_cmd(OP_SET_DOT, 4'd0, 4'd0, 3'd7);
        push_cmd(OP_SET_DOT, 4'd15, 4'd15, 3'd7);
        push_cmd(OP_SET_DOT, 4'd0, 4'd1, 3'd1);
        push_cmd(OP_SET_DOT, 4'd15, 4'd14, 3'd2);
        push_cmd(OP_SET_DOT, 4'd5, 4'd9, 3'd4);
        push_cmd(OP_SET_DOT, 4'd3, 4'd3, 3'd0);
        push_cmd(OP_CLEAR, 4'd0, 4'd0, 3'd0);
        push_cmd(OP_SET_DOT, 4'd0, 4'd0, 3'd7);
        push_cmd(OP_SET_DOT, 4'd15, 4'd15, 3'd7);
        push_cmd(OP_SET_DOT, 4'd7, 4'd8, 3'd3);
        push_cmd(OP_SET_DOT, 4'd9, 4'd6, 3'd6);
        push_cmd(OP_SET_DOT, 4'd12, 4'd2, 3'd5);
        push_cmd(OP_START, 4'd0, 4'd0, 3'd0);
        push_cmd(OP_START, 4'd15, 4'd15, 3'd7);
        push_ticks(3);
        push_cmd(OP_SET_DOT, 4'd1, 4'd0, 3'd7);
        push_ticks(3);
        push_cmd(OP_SET_DOT, 4'd0, 4'd0, 3'd0);
        push_ticks(2);
        wait_drained();

        reg_write(DWELL_ADDR, '0);
        reg_write(SPARE_ADDR, 32'hFFFF_FFFF);
        reg_read_check();

        // block fills while the receiver holds off
        gap_pct   <= 0;
        stall_pct <= 0;
        hold_req  <= 1'b1;
        repeat (100) push_random(15, 0, 0);
        wait_drained();
        scan_out_frame();

        for (int f = 0; f < 2; f++)
        begin
            set_pace();
            reg_write(DWELL_ADDR, APB_DATA_W'((f == 0) ? 1 : $urandom_range(6)));
            reg_read_check();
            repeat (40) push_random(85, 2, 0);
            push_cmd(OP_START, COORD_W'($urandom), COORD_W'($urandom), COLOUR_W'($urandom));
            wait_drained();
            scan_out_frame();
        end

        // longest dwell, rewritten while dwelling
        set_pace();
        reg_write(DWELL_ADDR, 32'h0000_FFFF);
        reg_read_check();
        push_cmd(OP_START, 4'd0, 4'd0, 3'd0);
        push_ticks(200);
        wait_drained();
        reg_write(DWELL_ADDR, 32'd1);
        reg_read_check();
        repeat (60) push_random(20, 2, 2);
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("led_matrix_scan_driver_tb passed");
        else
            $display("led_matrix_scan_driver_tb failed");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("led_matrix_scan_driver_tb failed");
        $finish;
    end

endmodule
